// ===== rtl/dcst_pkg.sv =====
package dcst_pkg;

   // widths of the configuration registers, the csr address, the stream payloads and the default counter
   localparam int CFG_WIDTH        = 16;
   localparam int CSR_ADDR_WIDTH   = 1;
   localparam int REQ_TDATA_WIDTH  = 8;
   localparam int RSP_TDATA_WIDTH  = 8;
   localparam int COUNT_WIDTH_DEF  = 16;

   // register reset values
   localparam logic [CFG_WIDTH-1:0] STROBE_TIMEOUT_RESET = 16'd170;
   localparam logic [CFG_WIDTH-1:0] PAUSE_TICKS_RESET    = 16'd50;

   // register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_STROBE_TIMEOUT = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PAUSE_TICKS    = 1'd1;

   // strobe level codes of one channel, bit 0 first strobe, bit 1 second
   localparam logic [1:0] LEVELS_OFF    = 2'b00;
   localparam logic [1:0] LEVELS_FIRST  = 2'b01;
   localparam logic [1:0] LEVELS_SECOND = 2'b10;

   // per channel slice of one tick
   typedef struct packed {
      logic first_key;
      logic second_key;
      logic sensor_edge;
   } lane_in_type;

endpackage

// ===== rtl/dual_channel_strobe_timer_unit.sv =====
// channel   | group                        | payload
// req       | req_tvalid req_tready        | req_tdata  [5:0] key one..four, sensor a, b edge
// rsp       | rsp_tvalid rsp_tready        | rsp_tdata  [3:0] strobe one..four
// csr       | csr_we csr_addr csr_wdata    | 0 strobe timeout ticks, 1 pause ticks
//
// one tick per cycle while req_tready is high: each channel lane updates its counters in the accept cycle
// result appears in the output register the cycle after the tick is accepted
// req_tready falls only while the output register is full and rsp_tready is low
// synchronous reset clears strobes and run counters and loads both pause counters
module dual_channel_strobe_timer_unit
   import dcst_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,   // key_one, key_two, key_three,
                                                   // key_four, sensor_a_edge, sensor_b_edge
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,   // strobe_one, strobe_two,
                                                   // strobe_three, strobe_four
   input  logic                       csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [CFG_WIDTH-1:0]       csr_wdata
);

   logic                              accept;
   logic                              out_free;
   logic [CFG_WIDTH-1:0]              timeout_ff;
   logic [CFG_WIDTH-1:0]              pause_ff;
   logic [CFG_WIDTH+COUNT_WIDTH-1:0]  timeout_ext;
   logic [CFG_WIDTH+COUNT_WIDTH-1:0]  pause_ext;
   logic [COUNT_WIDTH-1:0]            timeout_cnt;
   logic [COUNT_WIDTH-1:0]            pause_cnt;
   lane_in_type                       lane_a_in;
   lane_in_type                       lane_b_in;
   logic [1:0]                        levels_a;
   logic [1:0]                        levels_b;

   assign req_tready = out_free;
   assign accept     = req_tvalid && out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= STROBE_TIMEOUT_RESET;
         pause_ff   <= PAUSE_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_STROBE_TIMEOUT: timeout_ff <= csr_wdata;
            CSR_PAUSE_TICKS:    pause_ff   <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // fit register values to the counter width
   assign timeout_ext = {{COUNT_WIDTH{1'b0}}, timeout_ff};
   assign pause_ext   = {{COUNT_WIDTH{1'b0}}, pause_ff};
   assign timeout_cnt = timeout_ext[COUNT_WIDTH-1:0];
   assign pause_cnt   = pause_ext[COUNT_WIDTH-1:0];

   // split the tick into per channel slices
   assign lane_a_in = '{first_key: req_tdata[0], second_key: req_tdata[1],
                        sensor_edge: req_tdata[4]};
   assign lane_b_in = '{first_key: req_tdata[2], second_key: req_tdata[3],
                        sensor_edge: req_tdata[5]};

   dcst_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane_a (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .lane_in     (lane_a_in),
      .timeout_cnt (timeout_cnt),
      .pause_cnt   (pause_cnt),
      .levels_in   (levels_a)
   );

   dcst_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane_b (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .lane_in     (lane_b_in),
      .timeout_cnt (timeout_cnt),
      .pause_cnt   (pause_cnt),
      .levels_in   (levels_b)
   );

   dcst_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .levels_a   (levels_a),
      .levels_b   (levels_b),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .out_free   (out_free)
   );

endmodule

// ===== rtl/dcst_lane.sv =====
module dcst_lane
   import dcst_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  lane_in_type            lane_in,
   input  logic [COUNT_WIDTH-1:0] timeout_cnt,
   input  logic [COUNT_WIDTH-1:0] pause_cnt,
   output logic [1:0]             levels_in
);

   localparam logic [COUNT_WIDTH-1:0] PAUSE_INIT = COUNT_WIDTH'(PAUSE_TICKS_RESET);

   logic [1:0]             levels_ff;
   logic [COUNT_WIDTH-1:0] run_ff;
   logic [COUNT_WIDTH-1:0] run_in;
   logic [COUNT_WIDTH-1:0] pause_ff;
   logic [COUNT_WIDTH-1:0] pause_in;
   logic [COUNT_WIDTH-1:0] run_dec;
   logic [COUNT_WIDTH-1:0] pause_dec;

   // counters step down, saturating at zero
   assign run_dec   = (run_ff   != '0) ? run_ff   - 1'b1 : run_ff;
   assign pause_dec = (pause_ff != '0) ? pause_ff - 1'b1 : pause_ff;

   // sensor edge, then timeout, then key poll
   always_comb begin
      levels_in = levels_ff;
      run_in    = run_dec;
      pause_in  = pause_dec;
      if (lane_in.sensor_edge) begin
         levels_in = LEVELS_OFF;
         pause_in  = pause_cnt;
      end else if (levels_ff != LEVELS_OFF) begin
         if (run_dec == '0) begin
            levels_in = LEVELS_OFF;
            pause_in  = pause_cnt;
         end
      end else if (pause_dec == '0) begin
         if (lane_in.first_key) begin
            run_in    = timeout_cnt;
            levels_in = LEVELS_FIRST;
         end else if (lane_in.second_key) begin
            run_in    = timeout_cnt;
            levels_in = LEVELS_SECOND;
         end
      end
   end

   // channel state, advanced once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_OFF;
         run_ff    <= '0;
         pause_ff  <= PAUSE_INIT;
      end else if (accept) begin
         levels_ff <= levels_in;
         run_ff    <= run_in;
         pause_ff  <= pause_in;
      end
   end

   // at most one strobe of the channel is high
   assert property (@(posedge clock) disable iff (reset) !(levels_ff[0] && levels_ff[1]))
      else $error("both strobes of one channel high");

   // a sensor edge always leaves the channel idle
   assert property (@(posedge clock) disable iff (reset)
                    accept && lane_in.sensor_edge |=> levels_ff == LEVELS_OFF)
      else $error("strobe survived a sensor edge");

   // a strobe only starts once the pause has run out
   assert property (@(posedge clock) disable iff (reset)
                    accept && levels_ff == LEVELS_OFF && pause_ff > 1
                    |=> levels_ff == LEVELS_OFF)
      else $error("strobe started during pause");

   // a running strobe keeps its selection until it drops
   assert property (@(posedge clock) disable iff (reset)
                    accept && levels_ff != LEVELS_OFF && levels_in != LEVELS_OFF
                    |=> levels_ff == $past(levels_ff))
      else $error("running strobe changed selection");

endmodule

// ===== rtl/dcst_merge.sv =====
module dcst_merge
   import dcst_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [1:0]                 levels_a,
   input  logic [1:0]                 levels_b,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output logic                       out_free
);

   logic                       valid_ff;
   logic [RSP_TDATA_WIDTH-1:0] data_ff;

   // output register can take a new transaction when empty or draining
   assign out_free = !valid_ff || rsp_tready;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= accept;
      end
   end

   // combined strobe levels of both lanes
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= {{(RSP_TDATA_WIDTH-4){1'b0}}, levels_b, levels_a};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule
